### src/vertex_normal_accumulator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the vertex normal accumulator
// Short forms of concurrent assertions that are clocked on i_clk and
// disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef VERTEX_NORMAL_ACCUMULATOR_MACROS_SVH
`define VERTEX_NORMAL_ACCUMULATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VNA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VNA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/vna_pkg.sv
// ----------------------------------------------------------------------------
// vna_pkg
// Shared constants, mode codes and the request and result types of the
// normalisation unit.
// ----------------------------------------------------------------------------
package vna_pkg;

    localparam int VERTEX_DEPTH_DEF = 1024;
    localparam int COORD_BITS_DEF   = 16;
    localparam int INDEX_BITS       = 10;
    localparam int POS_BITS         = 16;
    localparam int SUM_BITS         = 52;
    localparam int COUNT_BITS       = 16;
    localparam int OUT_BITS         = 16;
    localparam int FRAC_BITS        = 14;
    localparam int REDUCE_BITS      = 30;

    localparam logic [1:0] MODE_LOAD     = 2'd0;
    localparam logic [1:0] MODE_TRIANGLE = 2'd1;
    localparam logic [1:0] MODE_QUERY    = 2'd2;

    typedef struct packed {
        logic                       start;
        logic signed [SUM_BITS-1:0] sum_x;
        logic signed [SUM_BITS-1:0] sum_y;
        logic signed [SUM_BITS-1:0] sum_z;
    } t_norm_req;

    typedef struct packed {
        logic                       done;
        logic                       degenerate;
        logic signed [OUT_BITS-1:0] nx;
        logic signed [OUT_BITS-1:0] ny;
        logic signed [OUT_BITS-1:0] nz;
    } t_norm_res;

endpackage

### src/vertex_normal_accumulator.sv
// ----------------------------------------------------------------------------
// vertex_normal_accumulator
// Area-weighted vertex normals: position memory, accumulator memory, a
// shared multiplier for the face cross product and a normalisation unit.
// ----------------------------------------------------------------------------
// Load writes the position and clears the sums. Triangle: three position reads, six
// products on one multiplier and three read-modify-writes. Query: an accumulator read,
// up to 22 single-bit range-reduction shifts, a sum of squares, the 32-step square
// root and three divisions; a vertex with no faces or a zero sum skips the rest. The
// result waits for the output to be free. One item at a time.
// After reset a clearing pass zeroes the sums and counts of every vertex.
module vertex_normal_accumulator #(
    parameter int VERTEX_DEPTH = vna_pkg::VERTEX_DEPTH_DEF,
    parameter int COORD_BITS   = vna_pkg::COORD_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [1:0]                             i_mode,
    input  logic [vna_pkg::INDEX_BITS-1:0]         i_vertex_index,
    input  logic signed [vna_pkg::POS_BITS-1:0]    i_pos_x,
    input  logic signed [vna_pkg::POS_BITS-1:0]    i_pos_y,
    input  logic signed [vna_pkg::POS_BITS-1:0]    i_pos_z,
    input  logic [vna_pkg::INDEX_BITS-1:0]         i_corner_a,
    input  logic [vna_pkg::INDEX_BITS-1:0]         i_corner_b,
    input  logic [vna_pkg::INDEX_BITS-1:0]         i_corner_c,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [vna_pkg::OUT_BITS-1:0]    o_normal_x,
    output logic signed [vna_pkg::OUT_BITS-1:0]    o_normal_y,
    output logic signed [vna_pkg::OUT_BITS-1:0]    o_normal_z,
    output logic [vna_pkg::COUNT_BITS-1:0]         o_face_count,
    output logic                                   o_degenerate
);

    localparam int ADDR_W = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
    localparam int IW     = vna_pkg::INDEX_BITS;
    localparam int CW     = COORD_BITS;
    localparam int EW     = CW + 1;
    localparam int PW     = 2 * EW;
    localparam int NW     = PW + 1;
    localparam int SW     = vna_pkg::SUM_BITS;
    localparam int KW     = vna_pkg::COUNT_BITS;
    localparam int OW     = vna_pkg::OUT_BITS;

    localparam logic [3:0] ST_CLEAR    = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_LOAD     = 4'd2;
    localparam logic [3:0] ST_TRI_RA   = 4'd3;
    localparam logic [3:0] ST_TRI_RB   = 4'd4;
    localparam logic [3:0] ST_TRI_RC   = 4'd5;
    localparam logic [3:0] ST_TRI_EDGE = 4'd6;
    localparam logic [3:0] ST_TRI_MUL  = 4'd7;
    localparam logic [3:0] ST_TRI_RD   = 4'd8;
    localparam logic [3:0] ST_TRI_WR   = 4'd9;
    localparam logic [3:0] ST_Q_RD     = 4'd10;
    localparam logic [3:0] ST_Q_WAIT   = 4'd11;
    localparam logic [3:0] ST_Q_NORM   = 4'd12;
    localparam logic [3:0] ST_Q_OUT    = 4'd13;

    typedef struct packed {
        logic signed [SW-1:0] sx;
        logic signed [SW-1:0] sy;
        logic signed [SW-1:0] sz;
        logic [KW-1:0]        cnt;
    } t_acc;

    // Memories
    logic [3*CW-1:0]      r_pos_mem [VERTEX_DEPTH];
    t_acc                 r_acc_mem [VERTEX_DEPTH];
    logic [3*CW-1:0]      r_pos_q;
    t_acc                 r_acc_q;

    // Control and payload registers
    logic [3:0]           r_state;
    logic [ADDR_W-1:0]    r_clr_addr;
    logic [IW-1:0]        r_vi;
    logic [3*CW-1:0]      r_pos_in;
    logic [IW-1:0]        r_ca;
    logic [IW-1:0]        r_cb;
    logic [IW-1:0]        r_cc;
    logic [3*CW-1:0]      r_pa;
    logic [3*CW-1:0]      r_pb;
    logic signed [EW-1:0] r_e1 [3];
    logic signed [EW-1:0] r_e2 [3];
    logic [2:0]           r_step;
    logic signed [PW-1:0] r_prod;
    logic signed [NW-1:0] r_n [3];
    logic [1:0]           r_corner_sel;
    logic signed [OW-1:0] r_res_nx;
    logic signed [OW-1:0] r_res_ny;
    logic signed [OW-1:0] r_res_nz;
    logic [KW-1:0]        r_res_cnt;
    logic                 r_res_deg;
    logic                 r_out_valid;
    logic signed [OW-1:0] r_out_nx;
    logic signed [OW-1:0] r_out_ny;
    logic signed [OW-1:0] r_out_nz;
    logic [KW-1:0]        r_out_cnt;
    logic                 r_out_deg;

    // Combinational signals
    logic                 accept;
    logic                 vi_ok;
    logic                 tri_ok;
    logic [ADDR_W-1:0]    pos_raddr;
    logic [ADDR_W-1:0]    acc_raddr;
    logic                 pos_we;
    logic                 acc_we;
    logic [ADDR_W-1:0]    acc_waddr;
    t_acc                 acc_wdata;
    logic [IW-1:0]        corner;
    logic signed [EW-1:0] mul_a;
    logic signed [EW-1:0] mul_b;
    logic signed [CW-1:0] pa [3];
    logic signed [CW-1:0] pb [3];
    logic signed [CW-1:0] pc [3];
    logic                 out_free;
    vna_pkg::t_norm_req   norm_req;
    vna_pkg::t_norm_res   norm_res;

    function automatic logic in_range(input logic [IW-1:0] idx);
        return (32'(idx) < 32'(VERTEX_DEPTH));
    endfunction

    // Low COORD_BITS bits of the field, read as a signed coordinate.
    function automatic logic [CW-1:0] f_coord(input logic [vna_pkg::POS_BITS-1:0] raw);
        return CW'(raw);
    endfunction

    function automatic logic signed [SW-1:0] f_sat(input logic signed [SW-1:0] s,
                                                    input logic signed [NW-1:0] d);
        logic signed [SW:0] r;
        r = (SW+1)'(s) + (SW+1)'(d);
        if (r[SW] != r[SW-1]) begin
            return r[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end
        return r[SW-1:0];
    endfunction

    assign accept   = i_valid && o_ready;
    assign vi_ok    = in_range(i_vertex_index);
    assign tri_ok   = in_range(i_corner_a) && in_range(i_corner_b) && in_range(i_corner_c);
    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pa[i] = r_pa[i*CW +: CW];
            pb[i] = r_pb[i*CW +: CW];
            pc[i] = r_pos_q[i*CW +: CW];
        end
    end

    always_comb begin
        case (r_corner_sel)
            2'd0:    corner = r_ca;
            2'd1:    corner = r_cb;
            default: corner = r_cc;
        endcase
    end

    always_comb begin
        case (r_state)
            ST_TRI_RA: pos_raddr = ADDR_W'(r_ca);
            ST_TRI_RB: pos_raddr = ADDR_W'(r_cb);
            default:   pos_raddr = ADDR_W'(r_cc);
        endcase
        acc_raddr = (r_state == ST_Q_RD) ? ADDR_W'(r_vi) : ADDR_W'(corner);
    end

    // Operand selection for the shared multiplier, one cross-product term a step.
    always_comb begin
        case (r_step)
            3'd0: begin
                mul_a = r_e1[1];
                mul_b = r_e2[2];
            end
            3'd1: begin
                mul_a = r_e1[2];
                mul_b = r_e2[1];
            end
            3'd2: begin
                mul_a = r_e1[2];
                mul_b = r_e2[0];
            end
            3'd3: begin
                mul_a = r_e1[0];
                mul_b = r_e2[2];
            end
            3'd4: begin
                mul_a = r_e1[0];
                mul_b = r_e2[1];
            end
            3'd5: begin
                mul_a = r_e1[1];
                mul_b = r_e2[0];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        pos_we    = 1'b0;
        acc_we    = 1'b0;
        acc_waddr = ADDR_W'(r_vi);
        acc_wdata = '0;
        case (r_state)
            ST_CLEAR: begin
                acc_we    = 1'b1;
                acc_waddr = r_clr_addr;
            end
            ST_LOAD: begin
                pos_we = 1'b1;
                acc_we = 1'b1;
            end
            ST_TRI_WR: begin
                acc_we        = 1'b1;
                acc_waddr     = ADDR_W'(corner);
                acc_wdata.sx  = f_sat(r_acc_q.sx, r_n[0]);
                acc_wdata.sy  = f_sat(r_acc_q.sy, r_n[1]);
                acc_wdata.sz  = f_sat(r_acc_q.sz, r_n[2]);
                acc_wdata.cnt = (r_acc_q.cnt == {KW{1'b1}}) ? r_acc_q.cnt
                                                            : r_acc_q.cnt + KW'(1);
            end
            default: begin
                pos_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            r_pos_mem[ADDR_W'(r_vi)] <= r_pos_in;
        end
        r_pos_q <= r_pos_mem[pos_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (acc_we) begin
            r_acc_mem[acc_waddr] <= acc_wdata;
        end
        r_acc_q <= r_acc_mem[acc_raddr];
    end

    assign norm_req.start = (r_state == ST_Q_WAIT) && (r_acc_q.cnt != '0);
    assign norm_req.sum_x = r_acc_q.sx;
    assign norm_req.sum_y = r_acc_q.sy;
    assign norm_req.sum_z = r_acc_q.sz;

    vna_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (norm_req),
        .o_res   (norm_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // In ST_Q_OUT the output register is loaded below instead.
            if (r_out_valid && i_ready && (r_state != ST_Q_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (r_clr_addr == ADDR_W'(VERTEX_DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_vi     <= i_vertex_index;
                        r_pos_in <= {f_coord(i_pos_z), f_coord(i_pos_y), f_coord(i_pos_x)};
                        r_ca     <= i_corner_a;
                        r_cb     <= i_corner_b;
                        r_cc     <= i_corner_c;
                        case (i_mode)
                            vna_pkg::MODE_LOAD: begin
                                r_state <= vi_ok ? ST_LOAD : ST_IDLE;
                            end
                            vna_pkg::MODE_TRIANGLE: begin
                                r_state <= tri_ok ? ST_TRI_RA : ST_IDLE;
                            end
                            vna_pkg::MODE_QUERY: begin
                                if (vi_ok) begin
                                    r_state <= ST_Q_RD;
                                end else begin
                                    r_res_nx  <= '0;
                                    r_res_ny  <= '0;
                                    r_res_nz  <= '0;
                                    r_res_cnt <= '0;
                                    r_res_deg <= 1'b1;
                                    r_state   <= ST_Q_OUT;
                                end
                            end
                            default: begin
                                r_state <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_LOAD: begin
                    r_state <= ST_IDLE;
                end
                ST_TRI_RA: begin
                    r_state <= ST_TRI_RB;
                end
                ST_TRI_RB: begin
                    r_pa    <= r_pos_q;
                    r_state <= ST_TRI_RC;
                end
                ST_TRI_RC: begin
                    r_pb    <= r_pos_q;
                    r_state <= ST_TRI_EDGE;
                end
                ST_TRI_EDGE: begin
                    for (int i = 0; i < 3; i++) begin
                        r_e1[i] <= EW'(pc[i]) - EW'(pa[i]);
                        r_e2[i] <= EW'(pb[i]) - EW'(pa[i]);
                    end
                    r_step  <= '0;
                    r_state <= ST_TRI_MUL;
                end
                ST_TRI_MUL: begin
                    // Each product is registered and folded into its component next step.
                    r_prod <= PW'(mul_a) * PW'(mul_b);
                    case (r_step)
                        3'd1:    r_n[0] <= NW'(r_prod);
                        3'd2:    r_n[0] <= r_n[0] - NW'(r_prod);
                        3'd3:    r_n[1] <= NW'(r_prod);
                        3'd4:    r_n[1] <= r_n[1] - NW'(r_prod);
                        3'd5:    r_n[2] <= NW'(r_prod);
                        3'd6:    r_n[2] <= r_n[2] - NW'(r_prod);
                        default: r_n[0] <= r_n[0];
                    endcase
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd6) begin
                        r_corner_sel <= 2'd0;
                        r_state      <= ST_TRI_RD;
                    end
                end
                ST_TRI_RD: begin
                    r_state <= ST_TRI_WR;
                end
                ST_TRI_WR: begin
                    // The write lands before the next read, so a repeated corner adds twice.
                    if (r_corner_sel == 2'd2) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_corner_sel <= r_corner_sel + 2'd1;
                        r_state      <= ST_TRI_RD;
                    end
                end
                ST_Q_RD: begin
                    r_state <= ST_Q_WAIT;
                end
                ST_Q_WAIT: begin
                    r_res_cnt <= r_acc_q.cnt;
                    if (r_acc_q.cnt == '0) begin
                        r_res_nx  <= '0;
                        r_res_ny  <= '0;
                        r_res_nz  <= '0;
                        r_res_deg <= 1'b1;
                        r_state   <= ST_Q_OUT;
                    end else begin
                        r_state <= ST_Q_NORM;
                    end
                end
                ST_Q_NORM: begin
                    if (norm_res.done) begin
                        r_res_nx  <= norm_res.nx;
                        r_res_ny  <= norm_res.ny;
                        r_res_nz  <= norm_res.nz;
                        r_res_deg <= norm_res.degenerate;
                        r_state   <= ST_Q_OUT;
                    end
                end
                ST_Q_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_nx    <= r_res_nx;
                        r_out_ny    <= r_res_ny;
                        r_out_nz    <= r_res_nz;
                        r_out_cnt   <= r_res_cnt;
                        r_out_deg   <= r_res_deg;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_ready      = (r_state == ST_IDLE);
    assign o_valid      = r_out_valid;
    assign o_normal_x   = r_out_nx;
    assign o_normal_y   = r_out_ny;
    assign o_normal_z   = r_out_nz;
    assign o_face_count = r_out_cnt;
    assign o_degenerate = r_out_deg;

endmodule

### src/vna_norm.sv
// ----------------------------------------------------------------------------
// vna_norm
// Iterative normalisation of a summed normal: range reduction by single-bit
// shifts, sum of squares, bit-pair square root and a restoring divider that
// produces each Q1.14 component in turn.
// ----------------------------------------------------------------------------
module vna_norm (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vna_pkg::t_norm_req  i_req,
    output vna_pkg::t_norm_res  o_res
);

    localparam int MW   = vna_pkg::SUM_BITS;
    localparam int RB   = vna_pkg::REDUCE_BITS;
    localparam int FB   = vna_pkg::FRAC_BITS;
    localparam int QW   = vna_pkg::OUT_BITS;
    localparam int SQW  = 2 * RB + 4;
    localparam int LW   = RB + 2;
    localparam int NUMW = RB + FB + 1;
    localparam int CNTW = $clog2(QW);

    localparam logic [2:0] N_IDLE   = 3'd0;
    localparam logic [2:0] N_SHIFT  = 3'd1;
    localparam logic [2:0] N_SQ     = 3'd2;
    localparam logic [2:0] N_SQRT   = 3'd3;
    localparam logic [2:0] N_DIV_LD = 3'd4;
    localparam logic [2:0] N_DIV    = 3'd5;
    localparam logic [2:0] N_DONE   = 3'd6;

    logic [2:0]              r_state;
    logic [MW-1:0]           r_mag [3];
    logic                    r_neg [3];
    logic [1:0]              r_comp;
    logic [2*RB-1:0]         r_prod;
    logic [SQW-1:0]          r_x;
    logic [SQW-1:0]          r_root;
    logic [SQW-1:0]          r_bit;
    logic [QW-1:0]           r_num;
    logic [LW-1:0]           r_rem;
    logic [QW-1:0]           r_q;
    logic [CNTW-1:0]         r_cnt;
    logic signed [QW-1:0]    r_nrm [3];
    logic                    r_deg;

    logic [MW-1:0]           mag_sel;
    logic                    neg_sel;
    logic [RB-1:0]           op;
    logic                    big;
    logic                    all_zero;
    logic [SQW-1:0]          trial;
    logic                    sq_ge;
    logic [LW-1:0]           len;
    logic [NUMW-1:0]         num_full;
    logic [LW:0]             cand;
    logic                    div_ge;
    logic [QW-1:0]           q_fin;

    function automatic logic [MW-1:0] f_abs(input logic signed [MW-1:0] s);
        logic [MW-1:0] r;
        r = s[MW-1] ? MW'(-s) : MW'(s);
        return r;
    endfunction

    always_comb begin
        case (r_comp)
            2'd0: begin
                mag_sel = r_mag[0];
                neg_sel = r_neg[0];
            end
            2'd1: begin
                mag_sel = r_mag[1];
                neg_sel = r_neg[1];
            end
            2'd2: begin
                mag_sel = r_mag[2];
                neg_sel = r_neg[2];
            end
            default: begin
                mag_sel = '0;
                neg_sel = 1'b0;
            end
        endcase
    end

    assign op       = mag_sel[RB-1:0];
    assign big      = (|r_mag[0][MW-1:RB]) | (|r_mag[1][MW-1:RB]) | (|r_mag[2][MW-1:RB]);
    assign all_zero = (r_mag[0] == '0) && (r_mag[1] == '0) && (r_mag[2] == '0);
    assign trial    = r_root + r_bit;
    assign sq_ge    = (r_x >= trial);
    assign len      = r_root[LW-1:0];
    assign num_full = (NUMW'(op) << FB) + NUMW'(len >> 1);
    assign cand     = {r_rem, r_num[QW-1]};
    assign div_ge   = (cand >= {1'b0, len});
    assign q_fin    = {r_q[QW-2:0], div_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
        end else begin
            case (r_state)
                N_IDLE: begin
                    if (i_req.start) begin
                        r_mag[0] <= f_abs(i_req.sum_x);
                        r_mag[1] <= f_abs(i_req.sum_y);
                        r_mag[2] <= f_abs(i_req.sum_z);
                        r_neg[0] <= i_req.sum_x[MW-1];
                        r_neg[1] <= i_req.sum_y[MW-1];
                        r_neg[2] <= i_req.sum_z[MW-1];
                        r_deg    <= 1'b0;
                        r_state  <= N_SHIFT;
                    end
                end
                N_SHIFT: begin
                    if (all_zero) begin
                        r_nrm[0] <= '0;
                        r_nrm[1] <= '0;
                        r_nrm[2] <= '0;
                        r_deg    <= 1'b1;
                        r_state  <= N_DONE;
                    end else if (big) begin
                        r_mag[0] <= r_mag[0] >> 1;
                        r_mag[1] <= r_mag[1] >> 1;
                        r_mag[2] <= r_mag[2] >> 1;
                    end else begin
                        r_comp  <= 2'd0;
                        r_x     <= '0;
                        r_state <= N_SQ;
                    end
                end
                N_SQ: begin
                    // The square of one component is registered before it is added.
                    r_prod <= (2*RB)'(op) * (2*RB)'(op);
                    if (r_comp != 2'd0) begin
                        r_x <= r_x + SQW'(r_prod);
                    end
                    if (r_comp == 2'd3) begin
                        r_root  <= '0;
                        r_bit   <= SQW'(1) << (SQW - 2);
                        r_state <= N_SQRT;
                    end else begin
                        r_comp <= r_comp + 2'd1;
                    end
                end
                N_SQRT: begin
                    if (sq_ge) begin
                        r_x    <= r_x - trial;
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit == SQW'(1)) begin
                        r_comp  <= 2'd0;
                        r_state <= N_DIV_LD;
                    end
                end
                N_DIV_LD: begin
                    // The quotient stays below 2^16, so the top bits start as remainder.
                    r_num   <= num_full[QW-1:0];
                    r_rem   <= LW'(num_full[NUMW-1:QW]);
                    r_q     <= '0;
                    r_cnt   <= '0;
                    r_state <= N_DIV;
                end
                N_DIV: begin
                    r_rem <= div_ge ? LW'(cand - {1'b0, len}) : cand[LW-1:0];
                    r_num <= r_num << 1;
                    r_q   <= q_fin;
                    r_cnt <= r_cnt + CNTW'(1);
                    if (r_cnt == CNTW'(QW - 1)) begin
                        r_nrm[r_comp] <= neg_sel ? QW'(-q_fin) : q_fin;
                        if (r_comp == 2'd2) begin
                            r_state <= N_DONE;
                        end else begin
                            r_comp  <= r_comp + 2'd1;
                            r_state <= N_DIV_LD;
                        end
                    end
                end
                N_DONE: begin
                    r_state <= N_IDLE;
                end
                default: begin
                    r_state <= N_IDLE;
                end
            endcase
        end
    end

    assign o_res.done       = (r_state == N_DONE);
    assign o_res.degenerate = r_deg;
    assign o_res.nx         = r_nrm[0];
    assign o_res.ny         = r_nrm[1];
    assign o_res.nz         = r_nrm[2];

endmodule

### src/vna_checker.sv
// ----------------------------------------------------------------------------
// vna_checker
// Port-level checks on the result channel of the vertex normal accumulator,
// attached to the top level by a bind statement.
// ----------------------------------------------------------------------------
`include "vertex_normal_accumulator_macros.svh"

module vna_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_valid,
    input logic                                i_ready,
    input logic signed [vna_pkg::OUT_BITS-1:0] o_normal_x,
    input logic signed [vna_pkg::OUT_BITS-1:0] o_normal_y,
    input logic signed [vna_pkg::OUT_BITS-1:0] o_normal_z,
    input logic [vna_pkg::COUNT_BITS-1:0]      o_face_count,
    input logic                                o_degenerate
);

    // A result that is not taken stays offered.
    `VNA_ASSERT_NEXT(a_out_held, o_valid && !i_ready, o_valid && $stable(o_normal_x) && $stable(o_face_count), "result changed before transfer")

    // A degenerate result carries a zero vector.
    `VNA_ASSERT_SAME(a_degen_zero, o_valid && o_degenerate, (o_normal_x == 0) && (o_normal_y == 0) && (o_normal_z == 0), "degenerate result with non-zero normal")

    // A proper normal needs at least one face.
    `VNA_ASSERT_SAME(a_count_nonzero, o_valid && !o_degenerate, o_face_count != 0, "normal reported for a vertex without faces")

    // Components of a unit vector stay within one in Q1.14.
    `VNA_ASSERT_SAME(a_unit_range, o_valid, (o_normal_x <= 16'sd16384) && (o_normal_x >= -16'sd16384) && (o_normal_y <= 16'sd16384) && (o_normal_y >= -16'sd16384) && (o_normal_z <= 16'sd16384) && (o_normal_z >= -16'sd16384), "normal component out of range")

endmodule

bind vertex_normal_accumulator vna_checker u_vna_checker (.*);

### test/vertex_normal_accumulator_tb.sv
// ----------------------------------------------------------------------------
// vertex_normal_accumulator_tb
// Drives loads, triangles and queries through the valid/ready port, keeps a
// shadow of the positions, normal sums and face counts, and checks every query
// result field by field against the shadow's normal or its directed row's values.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator_tb;

    // Mode code that the block drops without any result.
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         NVERT       = vna_pkg::VERTEX_DEPTH_DEF;
    localparam longint     SUM_HI      = (64'sd1 <<< (vna_pkg::SUM_BITS - 1)) - 1;
    localparam longint     SUM_LO      = -SUM_HI - 1;
    localparam int         PEND_DEPTH  = 16;
    localparam int         DIR_MAX     = 32;

    typedef struct {
        logic [1:0]  mode;
        logic [9:0]  vidx;
        logic [15:0] px, py, pz;
        logic [9:0]  ca, cb, cc;
        bit          typed;
        logic [15:0] enx, eny, enz, ecnt;
        logic        edeg;
    } t_stim_row;

    typedef struct {
        logic [15:0] nx, ny, nz, cnt;
        logic        deg;
    } t_normal;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_mode = '0;
    logic [9:0]  i_vertex_index = '0;
    logic signed [15:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic [9:0]  i_corner_a = '0, i_corner_b = '0, i_corner_c = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic signed [15:0] o_normal_x, o_normal_y, o_normal_z;
    logic [15:0] o_face_count;
    logic        o_degenerate;

    vertex_normal_accumulator dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Shadow of the block's memories.
    longint      shadow_pos [NVERT][3];
    longint      shadow_sum [NVERT][3];
    int unsigned shadow_cnt [NVERT];
    bit          loaded [NVERT];
    int          loaded_list [NVERT];
    int          loaded_n = 0;
    // Expected results in order of their queries.
    t_normal     pend_mem [PEND_DEPTH];
    int          pend_wr = 0;
    int          pend_rd = 0;
    t_stim_row   directed [DIR_MAX];
    int          dir_n = 0;
    int          fail_count = 0;

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x  -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint sat_sum(longint s, longint d);
        longint r;
        r = s + d;
        if (r > SUM_HI) return SUM_HI;
        if (r < SUM_LO) return SUM_LO;
        return r;
    endfunction

    function automatic t_normal vertex_normal(int v);
        t_normal         r;
        longint unsigned mag[3], m, sq, len, q;
        int              k;
        r.cnt = 16'(shadow_cnt[v]);
        m     = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = shadow_sum[v][i] < 0 ? -shadow_sum[v][i] : shadow_sum[v][i];
            if (mag[i] > m) m = mag[i];
        end
        if (shadow_cnt[v] == 0 || m == 0) begin
            r.nx = 0; r.ny = 0; r.nz = 0; r.deg = 1'b1;
            return r;
        end
        k = 0;
        while ((m >> k) >= (64'd1 << vna_pkg::REDUCE_BITS)) k++;
        sq = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] >>= k;
            sq += mag[i] * mag[i];
        end
        len = int_sqrt(sq);
        for (int i = 0; i < 3; i++) begin
            q = (mag[i] * 16384 + (len >> 1)) / len;
            if (shadow_sum[v][i] < 0) q = (64'h10000 - q) & 64'hFFFF;
            if (i == 0) r.nx = q[15:0];
            else if (i == 1) r.ny = q[15:0];
            else r.nz = q[15:0];
        end
        r.deg = 1'b0;
        return r;
    endfunction

    // Updates the shadow for one accepted item; returns 1 when a result is due.
    function automatic bit apply_item(t_stim_row s, output t_normal res);
        longint e1[3], e2[3], n[3];
        int     corners[3];
        res = '{default: '0};
        case (s.mode)
            vna_pkg::MODE_LOAD: begin
                shadow_pos[s.vidx][0] = longint'($signed(s.px));
                shadow_pos[s.vidx][1] = longint'($signed(s.py));
                shadow_pos[s.vidx][2] = longint'($signed(s.pz));
                for (int i = 0; i < 3; i++) shadow_sum[s.vidx][i] = 0;
                shadow_cnt[s.vidx] = 0;
                if (!loaded[s.vidx]) begin
                    loaded[s.vidx] = 1'b1;
                    loaded_list[loaded_n] = int'(s.vidx);
                    loaded_n++;
                end
                return 1'b0;
            end
            vna_pkg::MODE_TRIANGLE: begin
                for (int i = 0; i < 3; i++) begin
                    e1[i] = shadow_pos[s.cc][i] - shadow_pos[s.ca][i];
                    e2[i] = shadow_pos[s.cb][i] - shadow_pos[s.ca][i];
                end
                n[0] = e1[1] * e2[2] - e1[2] * e2[1];
                n[1] = e1[2] * e2[0] - e1[0] * e2[2];
                n[2] = e1[0] * e2[1] - e1[1] * e2[0];
                corners = '{int'(s.ca), int'(s.cb), int'(s.cc)};
                foreach (corners[j]) begin
                    for (int i = 0; i < 3; i++)
                        shadow_sum[corners[j]][i] = sat_sum(shadow_sum[corners[j]][i], n[i]);
                    if (shadow_cnt[corners[j]] != 16'hFFFF) shadow_cnt[corners[j]]++;
                end
                return 1'b0;
            end
            vna_pkg::MODE_QUERY: begin
                res = vertex_normal(int'(s.vidx));
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic t_stim_row row(logic [1:0] md, int v, int x, int y, int z,
                                      int a, int b, int c);
        t_stim_row s;
        s = '{default: '0};
        s.mode = md; s.vidx = 10'(v); s.px = 16'(x); s.py = 16'(y); s.pz = 16'(z);
        s.ca = 10'(a); s.cb = 10'(b); s.cc = 10'(c);
        return s;
    endfunction

    function automatic t_stim_row typed_row(t_stim_row s, int nx, int ny, int nz,
                                            int cnt, bit deg);
        s.typed = 1'b1;
        s.enx = 16'(nx); s.eny = 16'(ny); s.enz = 16'(nz); s.ecnt = 16'(cnt);
        s.edeg = deg;
        return s;
    endfunction

    function automatic void add_row(t_stim_row s);
        directed[dir_n] = s;
        dir_n++;
    endfunction

    function automatic t_stim_row random_item();
        int        pick, n;
        t_stim_row s;
        pick = $urandom_range(0, 99);
        n    = loaded_n;
        if (pick < 20) begin
            if ($urandom_range(0, 3) == 0)
                s = row(vna_pkg::MODE_LOAD, $urandom_range(0, NVERT - 1),
                        $urandom_range(0, 1) ? 16'h7FFF : 16'h8000,
                        $urandom_range(0, 1) ? 16'h7FFF : 16'h8000,
                        $urandom_range(0, 1) ? 16'h7FFF : 16'h8000, 0, 0, 0);
            else
                s = row(vna_pkg::MODE_LOAD, $urandom_range(0, NVERT - 1), $urandom,
                        $urandom, $urandom, $urandom, $urandom, $urandom);
        end else if (pick < 65) begin
            s = row(vna_pkg::MODE_TRIANGLE, $urandom, $urandom, $urandom, $urandom,
                    loaded_list[$urandom_range(0, n - 1)],
                    loaded_list[$urandom_range(0, n - 1)],
                    loaded_list[$urandom_range(0, n - 1)]);
        end else if (pick < 95) begin
            // Mostly vertices in use, sometimes any vertex at all.
            s = row(vna_pkg::MODE_QUERY,
                    $urandom_range(0, 3) == 0 ? $urandom_range(0, NVERT - 1)
                                              : loaded_list[$urandom_range(0, n - 1)],
                    $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else begin
            s = row(MODE_UNUSED, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom);
        end
        return s;
    endfunction

    task automatic send_item(t_stim_row s, bit burst);
        t_normal res;
        int      gap;
        gap = burst ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_mode         <= s.mode;
        i_vertex_index <= s.vidx;
        i_pos_x        <= s.px;
        i_pos_y        <= s.py;
        i_pos_z        <= s.pz;
        i_corner_a     <= s.ca;
        i_corner_b     <= s.cb;
        i_corner_c     <= s.cc;
        do @(posedge i_clk); while (!o_ready);
        if (apply_item(s, res)) begin
            if (s.typed) begin
                res.nx = s.enx; res.ny = s.eny; res.nz = s.enz;
                res.cnt = s.ecnt; res.deg = s.edeg;
            end
            pend_mem[pend_wr % PEND_DEPTH] = res;
            pend_wr++;
        end
        @(negedge i_clk);
    endtask

    task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Result side: random stalls, each transfer checked against the oldest expectation.
    initial begin
        t_normal e;
        int      stall;
        bit      burst;
        stall = 0;
        burst = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (pend_wr == pend_rd) begin
                    $display("%0t: unexpected result, expected none, got n=%0h,%0h,%0h",
                             $time, o_normal_x, o_normal_y, o_normal_z);
                    fail_count++;
                end else begin
                    e = pend_mem[pend_rd % PEND_DEPTH];
                    pend_rd++;
                    check_field("normal_x", e.nx, o_normal_x);
                    check_field("normal_y", e.ny, o_normal_y);
                    check_field("normal_z", e.nz, o_normal_z);
                    check_field("face_count", e.cnt, o_face_count);
                    check_field("degenerate", 16'(e.deg), 16'(o_degenerate));
                end
                if ($urandom_range(0, 15) == 0) burst = !burst;
                stall = burst ? 0 : $urandom_range(0, 11);
            end
            @(negedge i_clk);
            if (stall > 0) begin
                i_ready <= 1'b0;
                stall--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        bit burst;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_row(typed_row(row(vna_pkg::MODE_QUERY, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 1));
        add_row(typed_row(row(vna_pkg::MODE_QUERY, 1023, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 1));
        add_row(row(vna_pkg::MODE_LOAD, 0, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0));
        add_row(row(vna_pkg::MODE_LOAD, 1, 16'h7FFF, 16'h8000, 16'h7FFF, 0, 0, 0));
        add_row(row(vna_pkg::MODE_LOAD, 2, 16'h8000, 16'h7FFF, 16'h7FFF, 0, 0, 0));
        add_row(typed_row(row(vna_pkg::MODE_QUERY, 2, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 1));
        add_row(row(vna_pkg::MODE_TRIANGLE, 0, 0, 0, 0, 0, 1, 2));
        add_row(row(vna_pkg::MODE_QUERY, 0, 0, 0, 0, 0, 0, 0));
        add_row(row(vna_pkg::MODE_QUERY, 1, 0, 0, 0, 0, 0, 0));
        add_row(row(vna_pkg::MODE_TRIANGLE, 0, 0, 0, 0, 2, 1, 0));
        add_row(row(vna_pkg::MODE_QUERY, 2, 0, 0, 0, 0, 0, 0));
        // A corner named twice gives a zero cross product but still counts twice.
        add_row(row(vna_pkg::MODE_LOAD, 1023, 16'h0100, 16'h0200, 16'hFF00, 0, 0, 0));
        add_row(row(vna_pkg::MODE_TRIANGLE, 0, 0, 0, 0, 1023, 1023, 1));
        add_row(typed_row(row(vna_pkg::MODE_QUERY, 1023, 0, 0, 0, 0, 0, 0), 0, 0, 0, 2, 1));
        add_row(row(vna_pkg::MODE_LOAD, 3, 16'h0100, 16'h0000, 16'h0000, 0, 0, 0));
        add_row(row(vna_pkg::MODE_LOAD, 4, 16'h0000, 16'h0100, 16'h0000, 0, 0, 0));
        add_row(row(vna_pkg::MODE_LOAD, 5, 16'h0000, 16'h0000, 16'h0100, 0, 0, 0));
        add_row(row(vna_pkg::MODE_TRIANGLE, 0, 0, 0, 0, 3, 4, 5));
        add_row(row(vna_pkg::MODE_QUERY, 3, 0, 0, 0, 0, 0, 0));
        add_row(row(MODE_UNUSED, 3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1023, 1023, 1023));
        // A reload clears the sums and the count.
        add_row(row(vna_pkg::MODE_LOAD, 3, 16'h0100, 16'h0000, 16'h0000, 0, 0, 0));
        add_row(typed_row(row(vna_pkg::MODE_QUERY, 3, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 1));
        add_row(row(vna_pkg::MODE_QUERY, 4, 0, 0, 0, 0, 0, 0));

        @(negedge i_clk);
        for (int i = 0; i < dir_n; i++) send_item(directed[i], 1'b0);

        burst = 1'b0;
        for (int i = 0; i < 1250; i++) begin
            if ($urandom_range(0, 31) == 0) burst = !burst;
            send_item(random_item(), burst);
        end
        i_valid <= 1'b0;

        while (pend_wr != pend_rd) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #60000000;
        $display("FAIL");
        $finish;
    end

endmodule

### vertex_normal_accumulator.f
+incdir+src
src/vna_pkg.sv
src/vna_norm.sv
src/vertex_normal_accumulator.sv
src/vna_checker.sv
test/vertex_normal_accumulator_tb.sv
